[src/aen_pkg.sv]
// aen_pkg: sizes, state and mode codes, and the control-word types of the
// and-not network evaluator. Used by every module of the block but aen_ram; depends on nothing.
`default_nettype none

package aen_pkg;

	localparam int NODES = 64;
	localparam int EDGES = 256;

	localparam int NODE_W  = 6;
	localparam int STATE_W = 2;
	localparam int MODE_W  = 2;
	localparam int CFG_W   = 7;

	localparam int EDGE_AW = (EDGES > 1) ? $clog2(EDGES) : 1;
	localparam int EDGE_CW = $clog2(EDGES + 1);

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;

	localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(64);

	localparam logic [STATE_W-1:0] ST_FALSE   = 2'd0;
	localparam logic [STATE_W-1:0] ST_TRUE    = 2'd1;
	localparam logic [STATE_W-1:0] ST_UNKNOWN = 2'd2;

	localparam logic [MODE_W-1:0] MODE_SET  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EVAL = 2'd2;

	typedef struct packed {
		logic              neg;
		logic [NODE_W-1:0] tgt;
		logic [NODE_W-1:0] src;
	} edge_t;

	typedef enum logic [2:0] {
		SP_IDLE,
		SP_MARK,
		SP_WAIT,
		SP_NODE,
		SP_EXEC,
		SP_EMIT_RD,
		SP_EMIT,
		SP_ERR
	} step_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_MARK,
		OP_LATCH,
		OP_EXEC,
		OP_EMIT_RD,
		OP_EMIT,
		OP_ERR
	} op_t;

	typedef enum logic [2:0] {
		CND_ALWAYS,
		CND_EVAL_GO,
		CND_NO_EDGES,
		CND_EDGES_LEFT,
		CND_EMIT_MORE
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		op_t   op;
		cond_t cond;
		logic  err_chk;
		logic  hold_busy;
		step_t jump_t;
		step_t jump_f;
	} ctrl_t;

	typedef struct packed {
		logic eval_go;
		logic no_edges;
		logic edges_left;
		logic src_unknown;
		logic out_busy;
		logic emit_more;
	} status_t;

endpackage

`default_nettype wire

[src/and_not_network_evaluator_core.sv]
// and_not_network_evaluator_core: top level of the and-not network evaluator.
// Holds the node_count register; depends on aen_pkg, aen_seq, aen_dp (aen_ram inside).
//
// The block takes one input beat at a time. A node-state write (mode 0), an edge
// append (mode 1) and an ignored mode 3 are each handled in the idle step. An evaluate
// beat (mode 2) runs a short microprogram: a step to mark edge targets unknown and,
// when edges are stored, a step to fetch the newest edge, then for each stored edge the
// node-state memory read of source and target, then the write-back of the target, then
// for each reported node a read through the node-state read port and an output load
// that waits while the output side stalls. A walk that meets an unknown source ends
// at once with a single error beat. No input is taken while an evaluation runs; the
// output register lets the final beat wait while new loads arrive.
// The node_count register is written over the cfg channel, which is always ready.
`default_nettype none

module and_not_network_evaluator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: node_count[6:0]
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [aen_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// node_index[5:0], node_value[7:6], edge_source[13:8], edge_target[19:14],
	// edge_negated[20], zero fill[23:21]
	input  logic [aen_pkg::IN_DATA_W-1:0]   s_tdata,
	// mode[1:0]
	input  logic [aen_pkg::MODE_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_node[5:0], out_value[7:6]
	output logic [aen_pkg::OUT_DATA_W-1:0]  m_tdata,
	// error[0]
	output logic                            m_tuser,
	output logic                            m_tlast
);

	import aen_pkg::*;

	logic [CFG_W-1:0]  node_count_q;
	logic [NODE_W-1:0] last_idx;
	ctrl_t             ctrl;
	status_t           st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// report at least one node and at most all of them
	always_comb begin
		if (node_count_q == '0) begin
			last_idx = '0;
		end else if (32'(node_count_q) >= NODES) begin
			last_idx = NODE_W'(NODES - 1);
		end else begin
			last_idx = NODE_W'(node_count_q - CFG_W'(1));
		end
	end

	assign s_tready = ctrl.in_ready;

	aen_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctrl   (ctrl)
	);

	aen_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.st       (st),
		.last_idx (last_idx),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

[src/aen_ram.sv]
// aen_ram: generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`default_nettype none

module aen_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[src/aen_seq.sv]
// aen_seq: step counter and microcode rom of the evaluator; emits one control word
// per step and branches on datapath status. Depends on aen_pkg.
`default_nettype none

module aen_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  aen_pkg::status_t st,
	output aen_pkg::ctrl_t   ctrl
);

	import aen_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  cond_ok;

	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		w = '{in_ready: 1'b0, op: OP_NONE, cond: CND_ALWAYS, err_chk: 1'b0,
			hold_busy: 1'b0, jump_t: SP_IDLE, jump_f: SP_IDLE};
		unique case (s)
			SP_IDLE: begin
				w.in_ready = 1'b1;
				w.op       = OP_LOAD;
				w.cond     = CND_EVAL_GO;
				w.jump_t   = SP_MARK;
				w.jump_f   = SP_IDLE;
			end
			SP_MARK: begin
				w.op     = OP_MARK;
				w.cond   = CND_NO_EDGES;
				w.jump_t = SP_EMIT_RD;
				w.jump_f = SP_WAIT;
			end
			// edge memory read latency
			SP_WAIT: begin
				w.jump_t = SP_NODE;
			end
			SP_NODE: begin
				w.op     = OP_LATCH;
				w.jump_t = SP_EXEC;
			end
			SP_EXEC: begin
				w.op      = OP_EXEC;
				w.err_chk = 1'b1;
				w.cond    = CND_EDGES_LEFT;
				w.jump_t  = SP_NODE;
				w.jump_f  = SP_EMIT_RD;
			end
			SP_EMIT_RD: begin
				w.op     = OP_EMIT_RD;
				w.jump_t = SP_EMIT;
			end
			SP_EMIT: begin
				w.op        = OP_EMIT;
				w.hold_busy = 1'b1;
				w.cond      = CND_EMIT_MORE;
				w.jump_t    = SP_EMIT_RD;
				w.jump_f    = SP_IDLE;
			end
			SP_ERR: begin
				w.op        = OP_ERR;
				w.hold_busy = 1'b1;
				w.jump_t    = SP_IDLE;
			end
			default: begin
				w.jump_t = SP_IDLE;
			end
		endcase
		return w;
	endfunction

	assign ctrl = ucode(step_q);

	always_comb begin
		unique case (ctrl.cond)
			CND_ALWAYS:     cond_ok = 1'b1;
			CND_EVAL_GO:    cond_ok = st.eval_go;
			CND_NO_EDGES:   cond_ok = st.no_edges;
			CND_EDGES_LEFT: cond_ok = st.edges_left;
			CND_EMIT_MORE:  cond_ok = st.emit_more;
			default:        cond_ok = 1'b1;
		endcase
	end

	always_comb begin
		if (ctrl.err_chk && st.src_unknown) begin
			step_d = SP_ERR;
		end else if (ctrl.hold_busy && st.out_busy) begin
			step_d = step_q;
		end else if (cond_ok) begin
			step_d = ctrl.jump_t;
		end else begin
			step_d = ctrl.jump_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= SP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	a_err_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == SP_EXEC && st.src_unknown) |=> step_q == SP_ERR)
		else $error("unknown source did not stop the walk");

	a_err_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == SP_ERR && !st.out_busy) |=> step_q == SP_IDLE)
		else $error("error beat did not end the run");

	a_exec_follows_latch: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == SP_EXEC |-> $past(step_q) == SP_NODE)
		else $error("edge executed without a node read");

endmodule

`default_nettype wire

[src/aen_dp.sv]
// aen_dp: evaluator datapath: edge memory, node-state memories with valid bits,
// walk pointer, report counter and the output register. Depends on aen_pkg, aen_ram.
`default_nettype none

module aen_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  aen_pkg::ctrl_t                  ctrl,
	output aen_pkg::status_t                st,
	input  logic [aen_pkg::NODE_W-1:0]      last_idx,
	input  logic                            s_tvalid,
	input  logic [aen_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [aen_pkg::MODE_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [aen_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tuser,
	output logic                            m_tlast
);

	import aen_pkg::*;

	function automatic logic in_range(logic [NODE_W-1:0] n);
		return 32'(n) < NODES;
	endfunction

	logic               accept;
	logic [NODE_W-1:0]  in_idx;
	logic [STATE_W-1:0] in_val;
	edge_t              in_edge;

	logic [EDGE_CW-1:0] edge_count_q;
	logic [EDGE_CW-1:0] ptr_q;
	logic [EDGE_CW-1:0] ptr_m1;
	logic [NODES-1:0]   tmask_q;
	logic [NODES-1:0]   valid_q;
	logic [NODE_W-1:0]  emit_idx_q;
	edge_t              edge_s1;
	edge_t              edge_rd;
	logic [$bits(edge_t)-1:0] edge_rd_raw;
	logic               edge_we;

	logic [NODE_W-1:0]  addr_a;
	logic [NODE_W-1:0]  addr_b;
	logic [STATE_W-1:0] rd_a;
	logic [STATE_W-1:0] rd_b;
	logic               va_s1;
	logic               vb_s1;
	logic [STATE_W-1:0] st_a;
	logic [STATE_W-1:0] st_b;
	logic               src_unknown;
	logic               lit;
	logic [STATE_W-1:0] new_t;

	logic               we_load;
	logic               we_exec;
	logic               node_we;
	logic [NODE_W-1:0]  node_waddr;
	logic [STATE_W-1:0] node_wdata;

	logic               busy;
	logic               load_out;
	logic               emit_last;
	logic               out_valid_q;
	logic [NODE_W-1:0]  out_node_q;
	logic [STATE_W-1:0] out_value_q;
	logic               out_err_q;
	logic               out_last_q;

	assign accept  = s_tvalid && ctrl.in_ready;
	assign in_idx  = s_tdata[5:0];
	assign in_val  = s_tdata[7:6];
	assign in_edge = '{neg: s_tdata[20], tgt: s_tdata[19:14], src: s_tdata[13:8]};

	assign edge_we = ctrl.op == OP_LOAD && accept && s_tuser == MODE_EDGE
		&& edge_count_q < EDGE_CW'(EDGES) && in_range(in_edge.src) && in_range(in_edge.tgt);

	assign ptr_m1 = ptr_q - EDGE_CW'(1);

	aen_ram #(.WIDTH($bits(edge_t)), .DEPTH(EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_count_q[EDGE_AW-1:0]),
		.wdata (in_edge),
		.raddr (ptr_m1[EDGE_AW-1:0]),
		.rdata (edge_rd_raw)
	);

	assign edge_rd = edge_t'(edge_rd_raw);

	// port a serves the source during the walk and the reported node while emitting
	assign addr_a = (ctrl.op == OP_EMIT_RD || ctrl.op == OP_EMIT) ? emit_idx_q : edge_rd.src;
	assign addr_b = edge_rd.tgt;

	// two copies of the node states so source and target are read together
	aen_ram #(.WIDTH(STATE_W), .DEPTH(NODES)) u_node_ram_a (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (addr_a),
		.rdata (rd_a)
	);

	aen_ram #(.WIDTH(STATE_W), .DEPTH(NODES)) u_node_ram_b (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (addr_b),
		.rdata (rd_b)
	);

	always_ff @(posedge clk) begin
		va_s1 <= valid_q[addr_a];
		vb_s1 <= valid_q[addr_b];
		if (ctrl.op == OP_LATCH) begin
			edge_s1 <= edge_rd;
		end
	end

	// an entry without its valid bit reads as unknown
	assign st_a = va_s1 ? rd_a : ST_UNKNOWN;
	assign st_b = vb_s1 ? rd_b : ST_UNKNOWN;

	assign src_unknown = st_a == ST_UNKNOWN;
	assign lit   = edge_s1.neg ? (st_a == ST_FALSE) : (st_a != ST_FALSE);
	assign new_t = (st_b != ST_FALSE && lit) ? ST_TRUE : ST_FALSE;

	assign we_load = ctrl.op == OP_LOAD && accept && s_tuser == MODE_SET && in_range(in_idx);
	assign we_exec = ctrl.op == OP_EXEC && !src_unknown;
	assign node_we = we_load || we_exec;
	assign node_waddr = we_exec ? edge_s1.tgt : in_idx;
	assign node_wdata = we_exec ? new_t : ((in_val > ST_UNKNOWN) ? ST_UNKNOWN : in_val);

	assign busy      = out_valid_q && !m_tready;
	assign load_out  = (ctrl.op == OP_EMIT || ctrl.op == OP_ERR) && !busy;
	assign emit_last = emit_idx_q == last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			tmask_q      <= '0;
			valid_q      <= '0;
			ptr_q        <= '0;
			emit_idx_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (edge_we) begin
				edge_count_q        <= edge_count_q + EDGE_CW'(1);
				tmask_q[in_edge.tgt] <= 1'b1;
			end
			if (ctrl.op == OP_MARK) begin
				valid_q <= valid_q & ~tmask_q;
			end else if (node_we) begin
				valid_q[node_waddr] <= 1'b1;
			end
			if (ctrl.op == OP_MARK) begin
				ptr_q      <= edge_count_q;
				emit_idx_q <= '0;
			end else if (ctrl.op == OP_LATCH) begin
				ptr_q <= ptr_m1;
			end
			if (ctrl.op == OP_EMIT && load_out && !emit_last) begin
				emit_idx_q <= emit_idx_q + NODE_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (ctrl.op == OP_ERR) begin
				out_node_q  <= edge_s1.src;
				out_value_q <= ST_UNKNOWN;
				out_err_q   <= 1'b1;
				out_last_q  <= 1'b1;
			end else begin
				out_node_q  <= emit_idx_q;
				out_value_q <= st_a;
				out_err_q   <= 1'b0;
				out_last_q  <= emit_last;
			end
		end
	end

	assign st = '{eval_go: accept && s_tuser == MODE_EVAL,
		no_edges: edge_count_q == '0,
		edges_left: ptr_q != '0,
		src_unknown: src_unknown,
		out_busy: busy,
		emit_more: !emit_last};

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_value_q, out_node_q};
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_last_q;

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= edge_count_q)
		else $error("walk pointer beyond stored edges");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && ctrl.op == OP_ERR) |=> m_tvalid && m_tuser && m_tlast)
		else $error("error beat not marked last");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
